### hdl/tsac_pkg.sv
// ---------------------------------------------------------------------------
// tsac_pkg: shared types and constants
// calibration constants, queue word layout and sequencer states
// ---------------------------------------------------------------------------
package tsac_pkg;

   localparam logic [15:0] CODE_LOW  = 16'h18a9;
   localparam logic [15:0] CODE_HIGH = 16'h32a6;
   localparam int unsigned CAL_A = 324;
   localparam int unsigned CAL_B = 424;
   localparam int unsigned CAL_C = 3159;
   localparam int unsigned CAL_D = 9411;
   localparam int TEMP_MAX = 8191;
   localparam int TEMP_MIN = -8192;

   // width of the kept count, wide enough for 64 codes
   localparam int CNT_W = 7;
   // sum of up to 64 codes of 16 bits
   localparam int SUM_W = 22;

   // one closed window handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } window_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_MUL,
      ST_RECIP,
      ST_SCALE,
      ST_OUT
   } back_state_type;

endpackage

### hdl/thermal_sample_average_convert_core.sv
// ---------------------------------------------------------------------------
// thermal_sample_average_convert_core: averaging temperature converter
// averages in-range sensor codes over a window and calibrates to decicelsius
// ---------------------------------------------------------------------------
//  channel | ports                         | direction
//  req     | req_valid/req_stall/raw_code  | in
//  rsp     | rsp_valid/rsp_stall/3 fields  | out
//  csr     | csr_write/csr_trim_word       | in
//
// one word per cycle is taken while the window queue has room
// a closed window makes two passes through the shared 40-step divider in the
// converter; an empty window skips the divider and goes straight to output
// synchronous active-high reset clears window state, queue and trim
// rsp_stall holds the result register; the queue then fills and stalls req
// ---------------------------------------------------------------------------
module thermal_sample_average_convert_core #(
   parameter int SAMPLES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_raw_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_temperature_decicelsius,
   output logic [4:0]         rsp_valid_samples,
   output logic               rsp_no_valid,
   input  logic               csr_write,
   input  logic [15:0]        csr_trim_word
);
   import tsac_pkg::*;

   logic [15:0] trim_ff;
   logic        win_valid, q_full, q_ne, q_pop;
   window_type  win_word, head_word;

   // trim register
   always_ff @(posedge clock) begin
      if (reset) trim_ff <= '0;
      else if (csr_write) trim_ff <= csr_trim_word;
   end

   tsac_front #(.SAMPLES(SAMPLES)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_raw_code(req_raw_code),
      .win_valid(win_valid), .win_stall(q_full), .win_word(win_word)
   );

   // queue of closed windows
   tsac_queue u_queue (
      .clock(clock), .reset(reset),
      .push(win_valid), .push_word(win_word), .full(q_full),
      .not_empty(q_ne), .pop(q_pop), .head_word(head_word)
   );

   tsac_back u_back (
      .clock(clock), .reset(reset), .trim_word(trim_ff),
      .win_ready(q_ne), .win_word(head_word), .win_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_temperature_decicelsius(rsp_temperature_decicelsius),
      .rsp_valid_samples(rsp_valid_samples), .rsp_no_valid(rsp_no_valid)
   );

endmodule

### hdl/tsac_div.sv
// ---------------------------------------------------------------------------
// tsac_div: unsigned restoring divider
// one quotient bit per cycle
// ---------------------------------------------------------------------------
module tsac_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CW-1:0]    n_ff, n_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         n_in = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### hdl/tsac_front.sv
// ---------------------------------------------------------------------------
// tsac_front: window accumulator
// keeps in-range codes, closes a window after SAMPLES codes
// ---------------------------------------------------------------------------
module tsac_front #(
   parameter int SAMPLES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [15:0]         req_raw_code,
   output logic                win_valid,
   input  logic                win_stall,
   output tsac_pkg::window_type win_word
);
   import tsac_pkg::*;

   localparam int PW = $clog2(SAMPLES + 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic             accept, keep, close;

   // hold input while the window queue is full
   assign req_stall = win_stall;
   assign accept = req_valid && !win_stall;
   assign keep = (req_raw_code >= CODE_LOW) && (req_raw_code <= CODE_HIGH);
   assign close = accept && (pos_ff == PW'(SAMPLES - 1));

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (accept) begin
         if (keep) begin
            sum_in = sum_ff + SUM_W'(req_raw_code);
            cnt_in = cnt_ff + 1'b1;
         end
         pos_in = pos_ff + 1'b1;
         if (close) begin
            sum_in = '0;
            cnt_in = '0;
            pos_in = '0;
         end
      end
   end

   assign win_valid = close;
   assign win_word.sum = keep ? sum_ff + SUM_W'(req_raw_code) : sum_ff;
   assign win_word.count = keep ? cnt_ff + 1'b1 : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

endmodule

### hdl/tsac_queue.sv
// ---------------------------------------------------------------------------
// tsac_queue: two-entry window queue
// decouples the accumulator from the converter
// ---------------------------------------------------------------------------
module tsac_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tsac_pkg::window_type push_word,
   output logic                 full,
   output logic                 not_empty,
   input  logic                 pop,
   output tsac_pkg::window_type head_word
);
   import tsac_pkg::*;

   window_type  mem_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head_word = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_word;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

### hdl/tsac_back.sv
// ---------------------------------------------------------------------------
// tsac_back: calibration sequencer
// averages, scales, trims and saturates one window
// ---------------------------------------------------------------------------
module tsac_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          trim_word,
   input  logic                 win_ready,
   input  tsac_pkg::window_type win_word,
   output logic                 win_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [13:0]   rsp_temperature_decicelsius,
   output logic [4:0]           rsp_valid_samples,
   output logic                 rsp_no_valid
);
   import tsac_pkg::*;

   localparam int NW = 40;
   localparam int DW = 24;
   // ceil(2^32 / 100): x*RECIP_100>>32 equals x/100 for x < 2^30
   localparam logic [25:0] RECIP_100 = 26'd42949673;

   back_state_type st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [15:0]      avg_ff;
   logic [24:0]      p424_ff, p324_ff;
   logic [NW-1:0]    num_ff;
   logic [DW-1:0]    den_ff;
   logic             start_ff, start_in;
   logic             div_done;
   logic [NW-1:0]    div_q;
   logic             out_v_ff;
   logic signed [13:0] t_ff, t_in;
   logic signed [13:0] temp_ff;
   logic [4:0]       vs_ff;
   logic             nv_ff;
   logic             take, out_free;
   logic [50:0]      q424, q324;
   logic signed [19:0] s_val;
   logic signed [35:0] prod;
   logic signed [35:0] scaled;
   logic signed [35:0] tv;

   assign out_free = !out_v_ff || !rsp_stall;
   assign take = (st_ff == ST_IDLE) && win_ready;
   assign win_pop = take;

   // first division: sum / count, second: scaled numerator / denominator
   tsac_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock(clock), .reset(reset), .start(start_ff),
      .numer(num_ff), .denom(den_ff), .done(div_done), .quot(div_q)
   );

   // divide by 100 through the reciprocal, products registered in ST_MUL
   assign q424 = {26'd0, p424_ff} * {25'd0, RECIP_100};
   assign q324 = {26'd0, p324_ff} * {25'd0, RECIP_100};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (take) st_in = (win_word.count != '0) ? ST_AVG : ST_OUT;
         ST_AVG: if (div_done) st_in = ST_MUL;
         ST_MUL: st_in = ST_RECIP;
         ST_RECIP: st_in = ST_SCALE;
         ST_SCALE: if (div_done) st_in = ST_OUT;
         ST_OUT: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      start_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: start_in = take && win_word.count != '0;
         ST_RECIP: start_in = 1'b1;
         default: start_in = 1'b0;
      endcase
   end

   // trim, scale and saturate, truncation toward zero on the 2^16 divide
   always_comb begin
      s_val = (trim_word[15]) ? $signed({1'b0, div_q[18:0]}) - $signed({5'd0, trim_word[14:0]})
                              : $signed({1'b0, div_q[18:0]}) + $signed({5'd0, trim_word[14:0]});
      prod = 36'(s_val) * 36'sd9411;
      scaled = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
      tv = scaled - 36'sd3159;
      if (tv > 36'(TEMP_MAX)) t_in = 14'sd8191;
      else if (tv < 36'(TEMP_MIN)) t_in = -14'sd8192;
      else t_in = 14'(tv);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cnt_ff <= win_word.count;
         num_ff <= NW'(win_word.sum);
         den_ff <= DW'(win_word.count);
      end
      if (st_ff == ST_AVG && div_done) avg_ff <= div_q[15:0];
      if (st_ff == ST_MUL) begin
         p424_ff <= {9'd0, avg_ff} * 25'(CAL_B);
         p324_ff <= {9'd0, avg_ff} * 25'(CAL_A);
      end
      if (st_ff == ST_RECIP) begin
         num_ff <= NW'(q424[50:32]) << 16;
         den_ff <= DW'(q324[50:32]) + 24'd65536;
      end
      if (st_ff == ST_SCALE && div_done) t_ff <= t_in;
      if (st_ff == ST_OUT && out_free) begin
         vs_ff <= (cnt_ff > CNT_W'(31)) ? 5'd31 : cnt_ff[4:0];
         nv_ff <= cnt_ff == '0;
         temp_ff <= (cnt_ff == '0) ? 14'sd0 : t_ff;
      end
      if (reset) begin
         st_ff <= ST_IDLE;
         start_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         start_ff <= start_in;
         if (st_ff == ST_OUT && out_free) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_valid_samples = vs_ff;
   assign rsp_no_valid = nv_ff;
   assign rsp_temperature_decicelsius = temp_ff;

endmodule
